>>> rtl/mexp_pkg.sv
// Shared types for the modular exponentiation block.
// Command and status records between the controller and the datapath.
// No dependencies.
package mexp_pkg;

  localparam int unsigned FieldW = 32;

  // Operand routing for one serial modular multiplication
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,  // base * 1 mod m, result into base
    OP_SQUARE = 2'd1,  // acc * acc mod m, result into acc
    OP_MULT   = 2'd2   // acc * base mod m, result into acc
  } mul_op_e;

  typedef struct packed {
    logic    load;      // capture a new request
    logic    start;     // launch a multiplication
    mul_op_e op;
    logic    next_bit;  // step to the next lower exponent bit
    logic    emit;      // move the result into the output register
  } mexp_cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_zero;
    logic cur_bit;
    logic last_bit;
    logic mul_done;
  } mexp_sts_t;

endpackage

>>> rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Instantiates mexp_ctrl and mexp_dp; uses mexp_pkg.
//
// Computes base ** exponent mod modulus by left-to-right square-and-multiply
// over the low OPERAND_BITS bits of each operand. A zero exponent gives 1
// (unreduced, also for modulus 1); a zero modulus with a nonzero exponent
// gives 0. One request is in work at a time. Each modular multiplication is
// bit-serial. A request costs one base reduction plus, per exponent bit, one
// square and one more multiplication when the bit is set. The result sits in
// an output register, and input ready rises together with output valid, so a
// new request is taken while the result waits.
module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FieldW-1:0] base_i,
  input  logic [FieldW-1:0] exponent_i,
  input  logic [FieldW-1:0] modulus_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [FieldW-1:0] power_mod_o
);

  mexp_cmd_t                 cmd;
  mexp_sts_t                 sts;
  logic [OPERAND_BITS-1:0]   result;
  logic                      out_free;
  logic                      out_valid_q;
  logic [FieldW-1:0]         power_mod_q;

  assign out_free = !out_valid_q || out_ready_i;

  mexp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mexp_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .modulus_i  (modulus_i),
    .sts_o      (sts),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      power_mod_q <= FieldW'(result);
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_mod_o = power_mod_q;

  // a request is only loaded when it is actually accepted
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load == (in_valid_i && in_ready_o))
    else $error("load does not match input handshake");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while one is in work");

  // multiplier never finishes while idle
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.mul_done |-> !in_ready_o)
    else $error("multiplier done outside a request");

  // zero exponent yields one
  a_exp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && sts.exp_zero) |=> (out_valid_o && power_mod_o == FieldW'(1)))
    else $error("zero exponent did not give one");

endmodule

>>> rtl/mexp_dp.sv
// Datapath: operand registers, exponent bit pointer and a bit-serial
// interleaved modular multiplier (one multiplier bit per cycle).
// Depends on mexp_pkg.
module mexp_dp import mexp_pkg::*; #(
  parameter int unsigned OPERAND_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mexp_cmd_t               cmd_i,
  input  logic [FieldW-1:0]       base_i,
  input  logic [FieldW-1:0]       exponent_i,
  input  logic [FieldW-1:0]       modulus_i,
  output mexp_sts_t               sts_o,
  output logic [OPERAND_BITS-1:0] result_o
);

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  base_q, exp_q, mod_q, acc_q;
  logic [W-1:0]  r_q, r_d, x_q, y_q;
  logic [CW-1:0] cnt_q, bit_idx_q;
  logic          busy_q, done_q;
  mul_op_e       dest_q;

  logic [W:0] mod_ext, dbl, dbl_red, sum, sum_red;

  // r = 2r mod m, then r = (r + bit*y) mod m; y never exceeds m
  always_comb begin
    mod_ext = {1'b0, mod_q};
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = {1'b0, dbl_red[W-1:0]} + (x_q[W-1] ? {1'b0, y_q} : '0);
    sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
    r_d     = sum_red[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      bit_idx_q <= '0;
      dest_q    <= OP_REDUCE;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.load) begin
        bit_idx_q <= CW'(W - 1);
      end else if (cmd_i.next_bit) begin
        bit_idx_q <= bit_idx_q - CW'(1);
      end
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W - 1);
        dest_q <= cmd_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= base_i[W-1:0];
      exp_q  <= exponent_i[W-1:0];
      mod_q  <= modulus_i[W-1:0];
      acc_q  <= W'(1);
    end
    if (cmd_i.start) begin
      r_q <= '0;
      case (cmd_i.op)
        OP_REDUCE: begin
          x_q <= base_q;
          y_q <= W'(1);
        end
        OP_SQUARE: begin
          x_q <= acc_q;
          y_q <= acc_q;
        end
        OP_MULT: begin
          x_q <= acc_q;
          y_q <= base_q;
        end
        default: begin
          x_q <= acc_q;
          y_q <= acc_q;
        end
      endcase
    end else if (busy_q) begin
      r_q <= r_d;
      x_q <= {x_q[W-2:0], 1'b0};
      if (cnt_q == '0) begin
        if (dest_q == OP_REDUCE) begin
          base_q <= r_d;
        end else begin
          acc_q <= r_d;
        end
      end
    end
  end

  always_comb begin
    sts_o.exp_zero = (exp_q == '0);
    sts_o.mod_zero = (mod_q == '0);
    sts_o.cur_bit  = exp_q[bit_idx_q];
    sts_o.last_bit = (bit_idx_q == '0);
    sts_o.mul_done = done_q;
    if (sts_o.exp_zero) begin
      result_o = W'(1);
    end else if (sts_o.mod_zero) begin
      result_o = '0;
    end else begin
      result_o = acc_q;
    end
  end

endmodule

>>> rtl/mexp_ctrl.sv
// Controller: sequences base reduction, then square and conditional
// multiply for each exponent bit, MSB first. Depends on mexp_pkg.
module mexp_ctrl import mexp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_free_i,
  input  mexp_sts_t sts_i,
  output mexp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_REDUCE, S_SQUARE, S_MULT, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, start: 1'b0, op: OP_SQUARE, next_bit: 1'b0, emit: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (sts_i.exp_zero || sts_i.mod_zero) begin
          state_d = S_OUT;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_REDUCE;
          state_d     = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (sts_i.mul_done) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = OP_SQUARE;
          state_d     = S_SQUARE;
        end
      end
      S_SQUARE: begin
        if (sts_i.mul_done) begin
          if (sts_i.cur_bit) begin
            cmd_o.start = 1'b1;
            cmd_o.op    = OP_MULT;
            state_d     = S_MULT;
          end else if (sts_i.last_bit) begin
            state_d = S_OUT;
          end else begin
            cmd_o.next_bit = 1'b1;
            cmd_o.start    = 1'b1;
            cmd_o.op       = OP_SQUARE;
          end
        end
      end
      S_MULT: begin
        if (sts_i.mul_done) begin
          if (sts_i.last_bit) begin
            state_d = S_OUT;
          end else begin
            cmd_o.next_bit = 1'b1;
            cmd_o.start    = 1'b1;
            cmd_o.op       = OP_SQUARE;
            state_d        = S_SQUARE;
          end
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    // ready is registered, so only take the request when the state agrees
    if (!ready_q) begin
      cmd_o.load = 1'b0;
      if (state_q == S_IDLE) begin
        state_d = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = ready_q;

endmodule
